[rtl/brf_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types of the byte ring FIFO.
package brf_pkg;

    localparam int BUFFER_SIZE_DEF = 4096;
    localparam int LANES_DEF       = 8;
    localparam int MAX_LANES       = 8;
    localparam int ADDR_W_MAX      = 16;

    localparam int OPCODE_W   = 3;
    localparam int LENGTH_W   = 13;
    localparam int DATA_W     = 64;
    localparam int ACCEPTED_W = 4;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 12;
    localparam int CONTIG_W   = 13;

    localparam logic [OPCODE_W-1:0] OP_ENQUEUE  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_DEQUEUE  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_PEEK     = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_ADV_WRITE = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_ADV_READ = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_CLEAR    = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_LEN  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_ROOM  = 2'd2;

    // One pass over the banks: a run of consecutive addresses that does not wrap.
    typedef struct packed {
        logic                  issue;
        logic                  wr;
        logic                  rd;
        logic [ADDR_W_MAX-1:0] base;
        logic [3:0]            count;
        logic [3:0]            offset;
        logic [DATA_W-1:0]     data;
    } seg_t;

    // Registered read result of one bank.
    typedef struct packed {
        logic       valid;
        logic [2:0] idx;
        logic [7:0] data;
    } lane_t;

endpackage

[rtl/brf_if.sv]
`timescale 1ns / 1ps
// Request and response channel interfaces of the byte ring FIFO.
interface brf_req_if;
    logic                              valid;
    logic                              ready;
    logic [brf_pkg::OPCODE_W-1:0]      opcode;
    logic [brf_pkg::LENGTH_W-1:0]      length;
    logic [brf_pkg::DATA_W-1:0]        write_bytes;

    modport source (output valid, output opcode, output length, output write_bytes,
                    input ready);
    modport sink (input valid, input opcode, input length, input write_bytes,
                  output ready);
endinterface

interface brf_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [brf_pkg::ACCEPTED_W-1:0]    accepted;
    logic [brf_pkg::STATUS_W-1:0]      status;
    logic [brf_pkg::DATA_W-1:0]        read_bytes;
    logic [brf_pkg::COUNT_W-1:0]       used_bytes;
    logic [brf_pkg::COUNT_W-1:0]       free_bytes;
    logic [brf_pkg::CONTIG_W-1:0]      contiguous_write;
    logic [brf_pkg::CONTIG_W-1:0]      contiguous_read;

    modport source (output valid, output accepted, output status, output read_bytes,
                    output used_bytes, output free_bytes, output contiguous_write,
                    output contiguous_read, input ready);
    modport sink (input valid, input accepted, input status, input read_bytes,
                  input used_bytes, input free_bytes, input contiguous_write,
                  input contiguous_read, output ready);
endinterface

[rtl/byte_ring_fifo.sv]
`timescale 1ns / 1ps
// Top level of the byte ring FIFO: control, pointers, banks and result register.
//
// Circular byte FIFO of BUFFER_SIZE bytes; one slot stays empty, so at most
// BUFFER_SIZE-1 bytes are held. Each request item carries an opcode: enqueue,
// dequeue or peek of 1..LANES bytes (all or nothing), advance of the write or
// read pointer by 1..BUFFER_SIZE (modulo the buffer, unchecked against the
// other pointer), or clear. Every item gives one response item with the count
// moved, status, bytes read and the used/free/contiguous sizes after the item.
// Rate: one item per cycle while responses are taken, but a transfer that
// crosses the end of the buffer holds the request channel for a second bank
// pass, because the bytes are spread over 2**ceil(log2(LANES)) byte banks (at
// least two; address modulo bank count) and each bank has one port, so the
// part after the wrap needs its own pass. A response enters the output register
// in state ST_FIN once that register is free (after ST_SEG2 for a wrapping
// transfer), right behind the registered bank read. The byte store is not
// cleared after reset; reading bytes never written returns unspecified data.
// The response register lets the next request enter while a response waits.
module byte_ring_fifo #(
    parameter int BUFFER_SIZE = brf_pkg::BUFFER_SIZE_DEF,
    parameter int LANES       = brf_pkg::LANES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    brf_req_if.sink   req,
    brf_rsp_if.source rsp
);

    localparam int PW   = $clog2(BUFFER_SIZE);
    localparam int LB   = (LANES <= 2) ? 1 : $clog2(LANES);
    localparam int NB   = 1 << LB;
    localparam int ROWS = (BUFFER_SIZE + NB - 1) / NB;
    localparam int SUMW = ((PW > brf_pkg::LENGTH_W) ? PW : brf_pkg::LENGTH_W) + 1;
    localparam logic [PW:0]   BSZ  = (PW+1)'(BUFFER_SIZE);
    localparam logic [SUMW-1:0] BSZW = SUMW'(BUFFER_SIZE);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SEG2 = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic          out_valid_reg;
    logic          seg_wr_reg, seg_rd_reg;
    logic [3:0]    n1_reg, n2_reg;
    logic [63:0]   wdata_reg;
    logic [1:0]    status_reg;
    logic [3:0]    acc_cnt_reg;
    logic [63:0]   acc_reg;

    logic [3:0]    out_acc_reg;
    logic [1:0]    out_status_reg;
    logic [63:0]   out_rbytes_reg;
    logic [11:0]   out_used_reg, out_free_reg;
    logic [12:0]   out_cw_reg, out_cr_reg;

    // sizes from the current pointers
    logic          wrapped;
    logic [PW-1:0] used_cnt, free_cnt;
    logic [PW:0]   cw_cnt, cr_cnt;

    // request decode
    logic          accept, out_free, load;
    logic          is_xfer, is_enq, len_ok, room_ok, xfer_go, adv_ok, n2_go;
    logic [3:0]    len4, n1, n2;
    logic [PW-1:0] base;
    logic [PW:0]   room;
    logic [1:0]    status_new;

    brf_pkg::seg_t  seg;
    brf_pkg::lane_t lanes [NB];
    logic [63:0]    merged;
    logic [NB-1:0]  ract_vec;

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p,
                                               input logic [brf_pkg::LENGTH_W-1:0] n);
        logic [SUMW-1:0] s;
        s = SUMW'(p) + SUMW'(n);
        if (s >= BSZW)
        begin
            s = s - BSZW;
        end
        return PW'(s);
    endfunction

    assign wrapped  = rp_reg > wp_reg;
    assign used_cnt = wrapped ? PW'(BSZ - {1'b0, rp_reg} + {1'b0, wp_reg}) : (wp_reg - rp_reg);
    assign free_cnt = PW'(BSZ - (PW+1)'(1) - {1'b0, used_cnt});
    // one byte less before the wrap when the read pointer sits at zero
    assign cw_cnt   = wrapped ? ({1'b0, rp_reg} - {1'b0, wp_reg} - (PW+1)'(1))
                              : (BSZ - {1'b0, wp_reg} - (PW+1)'(rp_reg == '0));
    assign cr_cnt   = wrapped ? (BSZ - {1'b0, rp_reg}) : {1'b0, wp_reg - rp_reg};

    assign out_free  = !out_valid_reg || rsp.ready;
    assign load      = (state_reg == ST_FIN) && out_free;
    assign req.ready = (state_reg == ST_IDLE) || load;
    assign accept    = req.valid && req.ready;

    assign is_enq  = req.opcode == brf_pkg::OP_ENQUEUE;
    assign is_xfer = is_enq || (req.opcode == brf_pkg::OP_DEQUEUE)
                     || (req.opcode == brf_pkg::OP_PEEK);
    assign len_ok  = (req.length != '0) && (req.length <= 13'(LANES));
    assign len4    = req.length[3:0];
    assign room_ok = is_enq ? (SUMW'(free_cnt) >= SUMW'(req.length))
                            : (SUMW'(used_cnt) >= SUMW'(req.length));
    assign xfer_go = is_xfer && len_ok && room_ok;
    assign adv_ok  = (req.length != '0) && (SUMW'(req.length) <= BSZW);

    // split a transfer at the end of the buffer
    assign base  = is_enq ? wp_reg : rp_reg;
    assign room  = BSZ - {1'b0, base};
    assign n1    = (SUMW'(len4) <= SUMW'(room)) ? len4 : 4'(room);
    assign n2    = len4 - n1;
    assign n2_go = xfer_go && (n2 != 4'd0);

    always_comb
    begin
        status_new = brf_pkg::STATUS_OK;
        if (is_xfer)
        begin
            priority if (!len_ok)
                status_new = brf_pkg::STATUS_BAD_LEN;
            else if (!room_ok)
                status_new = brf_pkg::STATUS_NO_ROOM;
            else
                status_new = brf_pkg::STATUS_OK;
        end
        else if ((req.opcode == brf_pkg::OP_ADV_WRITE) || (req.opcode == brf_pkg::OP_ADV_READ))
        begin
            status_new = adv_ok ? brf_pkg::STATUS_OK : brf_pkg::STATUS_BAD_LEN;
        end
    end

    always_comb
    begin
        rp_next = rp_reg;
        wp_next = wp_reg;
        if (accept)
        begin
            unique case (req.opcode)
                brf_pkg::OP_ENQUEUE:
                begin
                    if (xfer_go)
                        wp_next = wrap_add(wp_reg, req.length);
                end
                brf_pkg::OP_DEQUEUE:
                begin
                    if (xfer_go)
                        rp_next = wrap_add(rp_reg, req.length);
                end
                brf_pkg::OP_ADV_WRITE:
                begin
                    if (adv_ok)
                        wp_next = wrap_add(wp_reg, req.length);
                end
                brf_pkg::OP_ADV_READ:
                begin
                    if (adv_ok)
                        rp_next = wrap_add(rp_reg, req.length);
                end
                brf_pkg::OP_CLEAR:
                begin
                    rp_next = '0;
                    wp_next = '0;
                end
                default:
                begin
                    rp_next = rp_reg;
                end
            endcase
        end
    end

    // bank pass: first part straight from the request, wrapped part from 0
    always_comb
    begin
        seg = '0;
        if (accept)
        begin
            seg.issue  = 1'b1;
            seg.wr     = xfer_go && is_enq;
            seg.rd     = xfer_go && !is_enq;
            seg.base   = brf_pkg::ADDR_W_MAX'(base);
            seg.count  = xfer_go ? n1 : 4'd0;
            seg.offset = 4'd0;
            seg.data   = req.write_bytes;
        end
        else if (state_reg == ST_SEG2)
        begin
            seg.issue  = 1'b1;
            seg.wr     = seg_wr_reg;
            seg.rd     = seg_rd_reg;
            seg.base   = '0;
            seg.count  = n2_reg;
            seg.offset = n1_reg;
            seg.data   = wdata_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: state_next = accept ? (n2_go ? ST_SEG2 : ST_FIN) : ST_IDLE;
            ST_SEG2: state_next = ST_FIN;
            ST_FIN:
            begin
                if (load)
                    state_next = accept ? (n2_go ? ST_SEG2 : ST_FIN) : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    genvar gb;
    generate
        for (gb = 0; gb < NB; gb++)
        begin : g_bank
            brf_bank #(
                .BANK (gb),
                .LB   (LB),
                .PW   (PW),
                .ROWS (ROWS)
            ) u_bank (
                .clk   (clk),
                .rst_n (rst_n),
                .seg   (seg),
                .lane  (lanes[gb])
            );
            assign ract_vec[gb] = lanes[gb].valid;
        end
    endgenerate

    brf_merge #(
        .NB (NB)
    ) u_merge (
        .lanes (lanes),
        .bytes (merged)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
            seg_wr_reg    <= 1'b0;
            seg_rd_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            if (accept)
            begin
                seg_wr_reg <= xfer_go && is_enq;
                seg_rd_reg <= xfer_go && !is_enq;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            n1_reg      <= n1;
            n2_reg      <= n2;
            wdata_reg   <= req.write_bytes;
            status_reg  <= status_new;
            acc_cnt_reg <= xfer_go ? len4 : 4'd0;
            acc_reg     <= '0;
        end
        else if (state_reg == ST_SEG2)
        begin
            acc_reg <= acc_reg | merged;
        end
        // pointers already hold the state after this item
        if (load)
        begin
            out_acc_reg    <= acc_cnt_reg;
            out_status_reg <= status_reg;
            out_rbytes_reg <= acc_reg | merged;
            out_used_reg   <= 12'(used_cnt);
            out_free_reg   <= 12'(free_cnt);
            out_cw_reg     <= 13'(cw_cnt);
            out_cr_reg     <= 13'(cr_cnt);
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.accepted         = out_acc_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.read_bytes       = out_rbytes_reg;
    assign rsp.used_bytes       = out_used_reg;
    assign rsp.free_bytes       = out_free_reg;
    assign rsp.contiguous_write = out_cw_reg;
    assign rsp.contiguous_read  = out_cr_reg;

`ifndef SYNTHESIS
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (PW'(rp_reg) < BSZ) && ({1'b0, wp_reg} < BSZ))
        else $error("pointer outside buffer");

    a_seg2_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEG2) |-> $past(accept))
        else $error("second bank pass without a request");

    a_read_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(ract_vec) <= LANES)
        else $error("more bank reads than lanes");
`endif

endmodule

[rtl/brf_bank.sv]
`timescale 1ns / 1ps
// One byte bank: lane mapping, storage and registered read.
module brf_bank #(
    parameter int BANK = 0,
    parameter int LB   = 3,
    parameter int PW   = 12,
    parameter int ROWS = 512
) (
    input  logic          clk,
    input  logic          rst_n,
    input  brf_pkg::seg_t seg,
    output brf_pkg::lane_t lane
);

    localparam int RW = $clog2(ROWS);

    logic [7:0]    store_mem [ROWS];
    logic [LB-1:0] k;
    logic          active;
    logic [PW-1:0] addr;
    logic [RW-1:0] row;
    logic [3:0]    j;
    logic [7:0]    wbyte;
    logic          ract_reg;
    logic [2:0]    ridx_reg;
    logic [7:0]    rdata_reg;

    // distance of this bank from the first address of the pass
    assign k      = LB'(BANK) - seg.base[LB-1:0];
    assign active = (4'(k) < seg.count);
    assign addr   = seg.base[PW-1:0] + PW'(k);
    assign row    = RW'(addr >> LB);
    assign j      = seg.offset + 4'(k);
    assign wbyte  = seg.data[{j[2:0], 3'b000} +: 8];

    always_ff @(posedge clk)
    begin
        if (seg.issue && seg.wr && active)
        begin
            store_mem[row] <= wbyte;
        end
        if (seg.issue && seg.rd && active)
        begin
            rdata_reg <= store_mem[row];
        end
        if (seg.issue)
        begin
            ridx_reg <= j[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ract_reg <= 1'b0;
        end
        else if (seg.issue)
        begin
            ract_reg <= seg.rd && active;
        end
    end

    assign lane.valid = ract_reg;
    assign lane.idx   = ridx_reg;
    assign lane.data  = rdata_reg;

endmodule

[rtl/brf_merge.sv]
`timescale 1ns / 1ps
// Steers the bank read bytes into their item byte positions.
module brf_merge #(
    parameter int NB = 8
) (
    input  brf_pkg::lane_t               lanes [NB],
    output logic [brf_pkg::DATA_W-1:0]   bytes
);

    always_comb
    begin
        bytes = '0;
        for (int jj = 0; jj < brf_pkg::MAX_LANES; jj++)
        begin
            for (int b = 0; b < NB; b++)
            begin
                if (lanes[b].valid && (lanes[b].idx == 3'(jj)))
                begin
                    bytes[8*jj +: 8] = bytes[8*jj +: 8] | lanes[b].data;
                end
            end
        end
    end

endmodule
